### rtl/atan2_rational_approx_unit_assert.svh
// Assertion macros for the atan2 unit. The property body sees clk and rst_n.
`ifndef ATAN2_RATIONAL_APPROX_UNIT_ASSERT_SVH
`define ATAN2_RATIONAL_APPROX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ATAN2RA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATAN2RA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATAN2RA_ASSERT(lbl, prop, msg)
`define ATAN2RA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/atan2ra_pkg.sv
`default_nettype none
package atan2ra_pkg;

  localparam int DEF_INPUT_WIDTH   = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Q30 coefficients and angles
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;
  localparam logic [31:0] Q30_HALF    = 32'd536870912;
  localparam logic [31:0] COEF_C1     = 32'd338;
  localparam logic [31:0] COEF_C2     = 32'd1073713441;
  localparam logic [31:0] COEF_C3     = 32'd158312570;
  localparam logic [31:0] COEF_C4     = 32'd332840025;
  localparam logic [31:0] COEF_C5     = 32'd54011108;
  localparam logic [31:0] COEF_C6     = 32'd157951624;
  localparam logic [31:0] COEF_C7     = 32'd691988024;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // final divide: (num << 30) + den/2 fits 62 bits, quotient < 2^30
  localparam int DIV2_DW = 62;
  localparam int DIV2_QW = 30;

  // Q30 x Q30 product, rounded to nearest
  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'(Q30_HALF);
    return p[61:30];
  endfunction

endpackage
`default_nettype wire

### rtl/atan2ra_div.sv
`default_nettype none
`include "atan2_rational_approx_unit_assert.svh"
// Restoring divider, one quotient bit per pipeline stage, MSB first.
module atan2ra_div #(
  parameter int DW = 48,
  parameter int VW = 32,
  parameter int QW = 17,
  parameter int SW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ce,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_dividend,
  input  wire logic [VW-1:0] in_divisor,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quotient,
  output logic [SW-1:0]      out_side
);

  logic [DW-1:0] rem_r  [QW];
  logic [VW-1:0] dvs_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [DW-1:0] rem_in;
    logic [VW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [DW-1:0] sub;
    logic [DW:0]   diff;
    logic [QW-1:0] quo_nxt;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = in_dividend;
      assign dvs_in  = in_divisor;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      sub        = DW'(dvs_in) << B;
      diff       = {1'b0, rem_in} - {1'b0, sub};
      quo_nxt    = quo_in;
      quo_nxt[B] = ~diff[DW];
      rem_nxt    = diff[DW] ? rem_in : diff[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= rem_nxt;
        dvs_r[k]  <= dvs_in;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid    = vld_r[QW-1];
  assign out_quotient = quo_r[QW-1];
  assign out_side     = side_r[QW-1];

  `ATAN2RA_ASSERT(a_rem_below_divisor, out_valid && (dvs_r[QW-1] != '0) |-> rem_r[QW-1] < DW'(dvs_r[QW-1]), "divider remainder not below divisor")
  `ATAN2RA_ASSERT(a_stall_holds, !ce && out_valid |=> out_valid && $stable(out_quotient) && $stable(out_side), "divider output moved during stall")
  `ATAN2RA_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid, "divider valid survived reset")

endmodule
`default_nettype wire

### rtl/atan2_rational_approx_unit.sv
`default_nettype none
`include "atan2_rational_approx_unit_assert.svh"
// Channel  Dir  Payload (low bit up)                      Transaction when
// in_      in   tdata: y_value[IW], x_value[IW], zero pad  in_tvalid & in_tready
// out_     out  tdata: angle[F+3] signed Q.F rad, zero pad out_tvalid & out_tready
//
// One transaction per cycle sustained while out_tready stays high.
// Stages: 1 magnitude/compare, F+1 ratio divider bits, 4 Horner multiply stages,
// 30 final divider bits, 1 mirror, 1 round/negate. The two bit-per-stage dividers set depth.
// All stages advance together on one enable; a result held by out_tready low freezes the
// whole pipe, so nothing is dropped or repeated. Synchronous active-low reset clears the
// valid bits only.
module atan2_rational_approx_unit #(
  parameter int INPUT_WIDTH   = atan2ra_pkg::DEF_INPUT_WIDTH,
  parameter int FRACTION_BITS = atan2ra_pkg::DEF_FRACTION_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // y_value, x_value
  input  wire logic [((2*INPUT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // angle
  output logic [((FRACTION_BITS+3+7)/8)*8-1:0] out_tdata
);
  import atan2ra_pkg::*;

  localparam int IW  = INPUT_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int AW  = F + 3;
  localparam int OTW = ((AW + 7) / 8) * 8;
  localparam int D1W = IW + F + 1;   // ratio dividend width
  localparam int Q1W = F + 1;        // ratio 0..1.0 in Q.F
  localparam logic [32:0] RND = 33'd1 << (29 - F);
  localparam logic [AW-1:0] ANG_MAX = AW'((33'(PI_Q30) + RND) >> (30 - F));

  // global advance enable
  logic ce;
  assign ce        = out_tready | ~out_tvalid;
  assign in_tready = ce;

  // ---- stage 0: magnitudes and octant ----
  logic [IW-1:0] y_in, x_in, ay, ax;
  logic          swap;
  assign y_in = in_tdata[IW-1:0];
  assign x_in = in_tdata[2*IW-1:IW];
  assign ay   = y_in[IW-1] ? (~y_in + 1'b1) : y_in;
  assign ax   = x_in[IW-1] ? (~x_in + 1'b1) : x_in;
  assign swap = ay > ax;

  logic          s0_vld_r;
  logic [IW-1:0] hi_r, lo_r;
  logic [3:0]    s0_side_r;  // {swap, x_neg, y_neg, hi_zero}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (ce) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hi_r      <= swap ? ay : ax;
      lo_r      <= swap ? ax : ay;
      s0_side_r <= {swap, x_in[IW-1], y_in[IW-1], ((swap ? ay : ax) == '0)};
    end
  end

  // ---- ratio divider ----
  logic [D1W-1:0] d1_dividend;
  logic           d1_vld;
  logic [Q1W-1:0] d1_quo;
  logic [3:0]     d1_side;
  assign d1_dividend = (D1W'(lo_r) << F) + D1W'(hi_r >> 1);

  atan2ra_div #(.DW(D1W), .VW(IW), .QW(Q1W), .SW(4)) u_ratio_div (
    .clk, .rst_n, .ce,
    .in_valid(s0_vld_r), .in_dividend(d1_dividend), .in_divisor(hi_r), .in_side(s0_side_r),
    .out_valid(d1_vld), .out_quotient(d1_quo), .out_side(d1_side)
  );

  logic [31:0] r30;
  assign r30 = d1_side[0] ? '0 : (32'(d1_quo) << (30 - F));

  // ---- Horner stages ----
  logic        p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic [31:0] p1_r30_r, p2_r30_r, p3_r30_r;
  logic [31:0] t1_r, t2_r, t3_r, num_r;
  logic [31:0] dn1_r, dn2_r, dn3_r, den_r;
  logic [2:0]  p1_side_r, p2_side_r, p3_side_r, p4_side_r;  // {swap, x_neg, y_neg}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else if (ce) begin
      p1_vld_r <= d1_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_r30_r  <= r30;
      t1_r      <= COEF_C4 - mul_q30(COEF_C5, r30);
      dn1_r     <= COEF_C6 + mul_q30(COEF_C7, r30);
      p1_side_r <= d1_side[3:1];

      p2_r30_r  <= p1_r30_r;
      t2_r      <= COEF_C3 + mul_q30(p1_r30_r, t1_r);
      dn2_r     <= Q30_ONE + mul_q30(p1_r30_r, dn1_r);
      p2_side_r <= p1_side_r;

      p3_r30_r  <= p2_r30_r;
      t3_r      <= COEF_C2 + mul_q30(p2_r30_r, t2_r);
      dn3_r     <= dn2_r;
      p3_side_r <= p2_side_r;

      num_r     <= COEF_C1 + mul_q30(p3_r30_r, t3_r);
      den_r     <= dn3_r;
      p4_side_r <= p3_side_r;
    end
  end

  // ---- final divider: q = round(num / den) in Q30 ----
  logic [DIV2_DW-1:0] d2_dividend;
  logic               d2_vld;
  logic [DIV2_QW-1:0] d2_quo;
  logic [2:0]         d2_side;
  assign d2_dividend = (DIV2_DW'(num_r) << 30) + DIV2_DW'(den_r >> 1);

  atan2ra_div #(.DW(DIV2_DW), .VW(32), .QW(DIV2_QW), .SW(3)) u_angle_div (
    .clk, .rst_n, .ce,
    .in_valid(p4_vld_r), .in_dividend(d2_dividend), .in_divisor(den_r), .in_side(p4_side_r),
    .out_valid(d2_vld), .out_quotient(d2_quo), .out_side(d2_side)
  );

  // ---- mirror into octant / quadrant ----
  logic [31:0] m_a, m_b;
  always_comb begin
    m_a = 32'(d2_quo);
    if (d2_side[2]) m_a = (HALF_PI_Q30 >= m_a) ? (HALF_PI_Q30 - m_a) : '0;
    m_b = m_a;
    if (d2_side[1]) m_b = (PI_Q30 >= m_b) ? (PI_Q30 - m_b) : '0;
  end

  logic        mr_vld_r, mr_neg_r;
  logic [31:0] mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mr_vld_r <= 1'b0;
    end else if (ce) begin
      mr_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r    <= m_b;
      mr_neg_r <= d2_side[0];
    end
  end

  // ---- round to Q.F and apply sign ----
  logic [32:0]   rsum;
  logic [AW-1:0] res, angle_nxt;
  logic [AW-1:0] angle_r;
  logic          out_vld_r;
  assign rsum      = (33'(mag_r) + RND) >> (30 - F);
  assign res       = rsum[AW-1:0];
  assign angle_nxt = mr_neg_r ? (~res + 1'b1) : res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= mr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OTW'(angle_r);

  // zero divisor (origin) leaves an all-ones quotient that r30 discards
  `ATAN2RA_ASSERT(a_ratio_max_one, d1_vld && !d1_side[0] |-> d1_quo <= (Q1W'(1) << F), "ratio above 1.0")
  `ATAN2RA_ASSERT(a_q_below_half_pi, d2_vld |-> 32'(d2_quo) <= HALF_PI_Q30, "octant angle above pi/2")
  `ATAN2RA_ASSERT(a_angle_in_range, out_tvalid |-> ($signed(angle_r) <= $signed({1'b0, ANG_MAX})) && ($signed(angle_r) >= -$signed({1'b0, ANG_MAX})), "angle beyond pi")

endmodule
`default_nettype wire
